### rtl/core/ska_pkg.sv
`timescale 1ns / 1ps
package ska_pkg;

  localparam int KEY_W = 64;
  localparam int ID_W  = 7;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [ID_W-1:0]  id_t;

  typedef enum logic [1:0] {
    ACT_FIND  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_RESET = 2'd2,
    ACT_DUMP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_FROM_FIRST
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    logic     occupied;
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_sts_t;

endpackage

### rtl/core/ska_if.sv
`timescale 1ns / 1ps
interface ska_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  ska_pkg::key_t     key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface ska_out_if;
  logic              valid;
  logic              ready;
  ska_pkg::id_t      result_id;
  ska_pkg::key_t     key_out;
  logic              found;
  logic              table_full;
  logic              last;

  modport source (output valid, output result_id, output key_out, output found,
                  output table_full, output last, input ready);
  modport sink   (input valid, input result_id, input key_out, input found,
                  input table_full, input last, output ready);
endinterface

### rtl/core/ska_cell.sv
`timescale 1ns / 1ps
module ska_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ska_pkg::cell_ctl_t ctl,
  input  ska_pkg::key_t      search_key,
  input  ska_pkg::key_t      new_key,
  input  ska_pkg::id_t       new_id,
  input  ska_pkg::key_t      prev_key,
  input  ska_pkg::id_t       prev_id,
  input  ska_pkg::key_t      next_key,
  input  ska_pkg::id_t       next_id,
  input  ska_pkg::key_t      first_key,
  input  ska_pkg::id_t       first_id,
  output ska_pkg::key_t      key,
  output ska_pkg::id_t       id,
  output ska_pkg::cell_sts_t sts
);

  ska_pkg::key_t      key_r, key_nxt;
  ska_pkg::id_t       id_r, id_nxt;
  ska_pkg::cell_sts_t sts_r;

  always_comb begin
    key_nxt = key_r;
    id_nxt  = id_r;
    unique case (ctl.op)
      ska_pkg::CELL_HOLD: begin
      end
      ska_pkg::CELL_LOAD: begin
        key_nxt = new_key;
        id_nxt  = new_id;
      end
      ska_pkg::CELL_FROM_PREV: begin
        key_nxt = prev_key;
        id_nxt  = prev_id;
      end
      ska_pkg::CELL_FROM_NEXT: begin
        key_nxt = next_key;
        id_nxt  = next_id;
      end
      ska_pkg::CELL_FROM_FIRST: begin
        key_nxt = first_key;
        id_nxt  = first_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
    if (!rst_n) begin
      sts_r <= '0;
    end else if (ctl.capture) begin
      sts_r.lt <= ctl.occupied && (key_r < search_key);
      sts_r.eq <= ctl.occupied && (key_r == search_key);
    end
  end

  assign key = key_r;
  assign id  = id_r;
  assign sts = sts_r;

endmodule

### rtl/core/sorted_key_interning_table_core.sv
`timescale 1ns / 1ps
// Find, add, reset: the key is compared in every cell at once on acceptance, then the
// hit is resolved and cells shift for insertion once the output register is free.
// After its resolve step a dump rotates its entries out of cell 0, one entry a cycle
// while the output is not stalled. A new item is taken only when the core is idle.
// Reset (rst_n low, synchronous) empties the table; cell contents are not cleared.
module sorted_key_interning_table_core #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  ska_in_if.sink        in_ch,
  ska_out_if.source     out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_DUMP
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    dump_idx_r, dump_idx_nxt;
  ska_pkg::action_t    act_r;
  ska_pkg::key_t       key_r;

  logic                out_valid_r, out_valid_nxt;
  ska_pkg::id_t        out_id_r, out_id_nxt;
  ska_pkg::key_t       out_key_r, out_key_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_full_r, out_full_nxt;
  logic                out_last_r, out_last_nxt;

  ska_pkg::key_t       cell_key [DEPTH];
  ska_pkg::id_t        cell_id  [DEPTH];
  ska_pkg::cell_sts_t  cell_sts [DEPTH];
  ska_pkg::cell_ctl_t  cell_ctl [DEPTH];
  logic [DEPTH-1:0]    lt_vec, eq_vec;

  logic                in_fire, slot_free, hit, insert, rotate;
  ska_pkg::id_t        hit_id, new_id;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign new_id    = ska_pkg::id_t'(count_r) + ska_pkg::id_t'(1);

  always_comb begin
    hit_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      lt_vec[i] = cell_sts[i].lt;
      eq_vec[i] = cell_sts[i].eq;
      hit_id    = hit_id | (cell_id[i] & {ska_pkg::ID_W{cell_sts[i].eq}});
    end
  end

  assign hit    = |eq_vec;
  assign insert = (state_r == S_RESOLVE) && slot_free && (act_r == ska_pkg::ACT_ADD)
                  && (key_r != '0) && !hit && (count_r < CNT_W'(DEPTH));
  assign rotate = (state_r == S_DUMP) && slot_free;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic          lt_prev;
    ska_pkg::key_t nb_key;
    ska_pkg::id_t  nb_id;

    if (g == 0) begin : g_first
      assign lt_prev = 1'b1;
    end else begin : g_rest
      assign lt_prev = lt_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign nb_key = '0;
      assign nb_id  = '0;
    end else begin : g_mid
      assign nb_key = cell_key[g+1];
      assign nb_id  = cell_id[g+1];
    end

    always_comb begin
      cell_ctl[g].capture  = in_fire;
      cell_ctl[g].occupied = CNT_W'(g) < count_r;
      cell_ctl[g].op       = ska_pkg::CELL_HOLD;
      priority if (insert) begin
        if (lt_vec[g]) begin
          cell_ctl[g].op = ska_pkg::CELL_HOLD;
        end else if (lt_prev) begin
          cell_ctl[g].op = ska_pkg::CELL_LOAD;
        end else begin
          cell_ctl[g].op = ska_pkg::CELL_FROM_PREV;
        end
      end else if (rotate) begin
        if (CNT_W'(g) + CNT_W'(1) < count_r) begin
          cell_ctl[g].op = ska_pkg::CELL_FROM_NEXT;
        end else if (CNT_W'(g) + CNT_W'(1) == count_r) begin
          cell_ctl[g].op = ska_pkg::CELL_FROM_FIRST;
        end
      end else begin
        cell_ctl[g].op = ska_pkg::CELL_HOLD;
      end
    end

    ska_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[g]),
      .search_key (in_ch.key),
      .new_key    (key_r),
      .new_id     (new_id),
      .prev_key   (g == 0 ? key_r  : cell_key[(g == 0) ? 0 : g-1]),
      .prev_id    (g == 0 ? new_id : cell_id[(g == 0) ? 0 : g-1]),
      .next_key   (nb_key),
      .next_id    (nb_id),
      .first_key  (cell_key[0]),
      .first_id   (cell_id[0]),
      .key        (cell_key[g]),
      .id         (cell_id[g]),
      .sts        (cell_sts[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_key_nxt   = out_key_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt    = S_RESOLVE;
          dump_idx_nxt = '0;
        end
      end
      S_RESOLVE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_key_nxt   = key_r;
          out_found_nxt = 1'b0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          unique case (act_r)
            ska_pkg::ACT_RESET: begin
              count_nxt = '0;
            end
            ska_pkg::ACT_DUMP: begin
              if (count_r == '0) begin
                out_key_nxt = '0;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_DUMP;
              end
            end
            ska_pkg::ACT_FIND, ska_pkg::ACT_ADD: begin
              if (key_r != '0) begin
                if (hit) begin
                  out_id_nxt    = hit_id;
                  out_found_nxt = 1'b1;
                end else if (act_r == ska_pkg::ACT_ADD) begin
                  if (insert) begin
                    out_id_nxt = new_id;
                    count_nxt  = count_r + CNT_W'(1);
                  end else begin
                    out_full_nxt = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (rotate) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = cell_id[0];
          out_key_nxt   = cell_key[0];
          out_found_nxt = 1'b1;
          out_full_nxt  = 1'b0;
          out_last_nxt  = (dump_idx_r + CNT_W'(1) == count_r);
          dump_idx_nxt  = dump_idx_r + CNT_W'(1);
          if (dump_idx_r + CNT_W'(1) == count_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= ska_pkg::action_t'(in_ch.action);
      key_r <= in_ch.key;
    end
    out_id_r    <= out_id_nxt;
    out_key_r   <= out_key_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_id  = out_id_r;
  assign out_ch.key_out    = out_key_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.table_full = out_full_r;
  assign out_ch.last       = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE) |-> $onehot0(eq_vec))
    else $error("key matched in more than one cell");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && slot_free && hit && act_r != ska_pkg::ACT_RESET)
    |=> $stable(count_r))
    else $error("entry count changed on a hit");

  a_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && slot_free && act_r == ska_pkg::ACT_RESET) |=> count_r == '0)
    else $error("table not emptied by reset item");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_RESOLVE)
    else $error("accepted item not resolved");
`endif

endmodule

### tb/sorted_key_interning_table_core_tb.sv
`timescale 1ns / 1ps
module sorted_key_interning_table_core_tb;
  import ska_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 370;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE       = 4 * DEPTH;

  typedef struct {
    id_t  id;
    key_t key;
    bit   found;
    bit   full;
    bit   last;
  } id_reply_t;

  typedef struct {
    action_t act;
    key_t    key;
    bit      typed;
    id_t     id;
    key_t    kout;
    bit      fnd;
    bit      full;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ska_in_if  in_ch ();
  ska_out_if out_ch ();

  sorted_key_interning_table_core #(.DEPTH(DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_t        tbl_key [DEPTH];
  id_t         tbl_id  [DEPTH];
  int unsigned tbl_count;

  id_reply_t pred_q [$];
  id_reply_t reply_q [$];
  key_t      pool [$];

  int n_items, n_results, n_dumps, n_refused, n_errors;
  int cycle_count;
  int stall_left;
  bit src_steady, sink_steady;

  localparam int N_DIR = 19;
  dir_row_t dir_rows [N_DIR] = '{
    '{ACT_FIND,  64'd5,                  1'b1, 7'd0, 64'd5,                  1'b0, 1'b0},
    '{ACT_DUMP,  64'h1234,               1'b1, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_ADD,   64'd0,                  1'b1, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_FIND,  64'd0,                  1'b1, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_ADD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{ACT_ADD,   64'd1,                  1'b1, 7'd2, 64'd1,                  1'b0, 1'b0},
    '{ACT_ADD,   64'h8000_0000_0000_0000, 1'b1, 7'd3, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
    '{ACT_ADD,   64'h0000_0000_FFFF_FFFF, 1'b1, 7'd4, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0},
    '{ACT_FIND,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
    '{ACT_ADD,   64'd1,                  1'b1, 7'd2, 64'd1,                  1'b1, 1'b0},
    '{ACT_FIND,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 7'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    '{ACT_DUMP,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_RESET, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 7'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0},
    '{ACT_FIND,  64'd1,                  1'b1, 7'd0, 64'd1,                  1'b0, 1'b0},
    '{ACT_DUMP,  64'd0,                  1'b1, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_ADD,   64'h5555_5555_5555_5555, 1'b1, 7'd1, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
    '{ACT_ADD,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 7'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0},
    '{ACT_DUMP,  64'd0,                  1'b0, 7'd0, 64'd0,                  1'b0, 1'b0},
    '{ACT_RESET, 64'd0,                  1'b1, 7'd0, 64'd0,                  1'b0, 1'b0}
  };

  function automatic id_reply_t mk_reply(id_t id, key_t key, bit found, bit full, bit last);
    id_reply_t r;
    r.id    = id;
    r.key   = key;
    r.found = found;
    r.full  = full;
    r.last  = last;
    return r;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic key_t fresh_key();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return 64'd1;
      3:       return 64'h8000_0000_0000_0000;
      4:       return key_t'($urandom_range(1, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_t pool_key();
    if (pool.size() == 0) return fresh_key();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function void intern_predict(action_t act, key_t key);
    int  pos;
    int  j;
    bit  hit;
    pred_q.delete();
    case (act)
      ACT_RESET: begin
        tbl_count = 0;
        pred_q.push_back(mk_reply('0, key, 1'b0, 1'b0, 1'b1));
      end
      ACT_DUMP: begin
        n_dumps++;
        if (tbl_count == 0) begin
          pred_q.push_back(mk_reply('0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          for (j = 0; j < tbl_count; j++)
            pred_q.push_back(mk_reply(tbl_id[j], tbl_key[j], 1'b1, 1'b0, j == tbl_count - 1));
        end
      end
      default: begin
        if (key == '0) begin
          pred_q.push_back(mk_reply('0, key, 1'b0, 1'b0, 1'b1));
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] < key) pos++;
          hit = (pos < tbl_count) && (tbl_key[pos] == key);
          if (hit) begin
            pred_q.push_back(mk_reply(tbl_id[pos], key, 1'b1, 1'b0, 1'b1));
          end else if (act == ACT_FIND) begin
            pred_q.push_back(mk_reply('0, key, 1'b0, 1'b0, 1'b1));
          end else if (tbl_count >= DEPTH) begin
            n_refused++;
            pred_q.push_back(mk_reply('0, key, 1'b0, 1'b1, 1'b1));
          end else begin
            for (j = tbl_count; j > pos; j--) begin
              tbl_key[j] = tbl_key[j-1];
              tbl_id[j]  = tbl_id[j-1];
            end
            tbl_key[pos] = key;
            tbl_id[pos]  = id_t'(tbl_count + 1);
            tbl_count++;
            pred_q.push_back(mk_reply(tbl_id[pos], key, 1'b0, 1'b0, 1'b1));
          end
        end
      end
    endcase
  endfunction

  task automatic send_item(action_t act, key_t key);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= key;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    intern_predict(act, key);
  endtask

  task automatic send_checked(action_t act, key_t key);
    send_item(act, key);
    foreach (pred_q[i]) reply_q.push_back(pred_q[i]);
  endtask

  // hold the sender off until every pending result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_episode(bit fill);
    int   r;
    key_t k;
    send_checked(ACT_RESET, {$urandom, $urandom});
    pool.delete();
    if (fill) begin
      repeat (DEPTH) begin
        k = {$urandom, $urandom} | 64'd1;
        send_checked(ACT_ADD, k);
        pool.push_back(k);
      end
      repeat ($urandom_range(6, 14)) begin
        r = $urandom_range(0, 3);
        case (r)
          0: send_checked(ACT_ADD, {$urandom, $urandom});
          1: send_checked(ACT_ADD, pool_key());
          2: send_checked(ACT_FIND, pool_key());
          default: send_checked(ACT_FIND, fresh_key());
        endcase
      end
    end else begin
      repeat ($urandom_range(4, 22)) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          k = fresh_key();
          send_checked(ACT_ADD, k);
          pool.push_back(k);
        end else if (r < 65) begin
          send_checked(ACT_ADD, pool_key());
        end else if (r < 88) begin
          send_checked(ACT_FIND, pool_key());
        end else if (r < 94) begin
          send_checked(ACT_FIND, fresh_key());
        end else if (r < 97) begin
          send_checked(ACT_DUMP, fresh_key());
        end else begin
          send_checked(ACT_RESET, fresh_key());
        end
      end
    end
    if ($urandom_range(0, 2) == 0) drain();
    send_checked(ACT_DUMP, {$urandom, $urandom});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap(sink_steady);
    end
  end

  always @(posedge clk) begin
    id_reply_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (reply_q.size() == 0) begin
        $error("result with nothing pending: result_id %0d key_out %h",
               out_ch.result_id, out_ch.key_out);
        n_errors++;
      end else begin
        w = reply_q.pop_front();
        if (out_ch.result_id !== w.id) begin
          $error("result_id: expected %0d, actual %0d", w.id, out_ch.result_id);
          n_errors++;
        end
        if (out_ch.key_out !== w.key) begin
          $error("key_out: expected %h, actual %h", w.key, out_ch.key_out);
          n_errors++;
        end
        if (out_ch.found !== w.found) begin
          $error("found: expected %0b, actual %0b", w.found, out_ch.found);
          n_errors++;
        end
        if (out_ch.table_full !== w.full) begin
          $error("table_full: expected %0b, actual %0b", w.full, out_ch.table_full);
          n_errors++;
        end
        if (out_ch.last !== w.last) begin
          $error("last: expected %0b, actual %0b", w.last, out_ch.last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, reply_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_FIND;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    tbl_count    = 0;
    src_steady   = 1'b0;
    sink_steady  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        send_item(dir_rows[i].act, dir_rows[i].key);
        reply_q.push_back(mk_reply(dir_rows[i].id, dir_rows[i].kout, dir_rows[i].fnd,
                                   dir_rows[i].full, 1'b1));
      end else begin
        send_checked(dir_rows[i].act, dir_rows[i].key);
      end
    end
    drain();

    run_episode(1'b1);
    while (n_items < N_DIR + RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      run_episode($urandom_range(0, 9) == 0);
    end

    in_ch.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items sent, %0d results checked over %0d dumps", n_items, n_results, n_dumps);
    $display("%0d adds refused on a full table, %0d mismatches", n_refused, n_errors);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
